// File: hdl/free_block_list_fit_search_macros.svh
// Assertion macros shared by the RTL of the free block list.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FREE_BLOCK_LIST_FIT_SEARCH_MACROS_SVH
`define FREE_BLOCK_LIST_FIT_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("free block list: assertion failed");

// Next-cycle implication, checked outside reset.
`define FBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("free block list: assertion failed");

`endif

// File: hdl/fbl_pkg.sv
// Types, codes and the controller/datapath interface of the free block list.
// Used by fbl_ctrl, fbl_dp and free_block_list_fit_search; no dependencies.
`default_nettype none

package fbl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_INSERT    = 3'd1;
  localparam logic [2:0] CMD_FIRST_FIT = 3'd2;
  localparam logic [2:0] CMD_BEST_FIT  = 3'd3;
  localparam logic [2:0] CMD_FIND_ADDR = 3'd4;
  localparam logic [2:0] CMD_REMOVE    = 3'd5;
  localparam logic [2:0] CMD_SHRINK    = 3'd6;
  localparam logic [2:0] CMD_READ      = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADINDEX = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] block_address;
    logic [31:0] block_size;
    logic [31:0] request_size;
    logic [5:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] found_address;
    logic [31:0] found_size;
    logic [6:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [1:0] {RD_PTR, RD_PREV, RD_NEXT} rd_sel_e;
  typedef enum logic [1:0] {WR_RD, WR_ITEM, WR_SHRUNK} wr_sel_e;
  typedef enum logic [2:0] {RES_ERR, RES_RD, RES_ITEM, RES_SHRUNK, RES_BEST} res_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic       load_item;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       ptr_ld_cnt;
    logic       ptr_ld_idx;
    logic       pos_ld;
    logic       best_clr;
    logic       best_ld;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    wr_sel_e    wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_ld;
    res_sel_e   res_sel;
    logic [1:0] res_status;
    logic       out_ld;
  } fbl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       idx_bad;
    logic       ptr_end;
    logic       ptr_gt_pos;
    logic       pull_end;
    logic       addr_lt;
    logic       addr_eq;
    logic       size_fit;
    logic       size_better;
    logic       shrink_bad;
    logic       hit;
  } fbl_stat_t;

endpackage

`default_nettype wire

// File: hdl/free_block_list_fit_search.sv
// Top level of the free block list with first-fit and best-fit search.
// Depends on fbl_pkg, fbl_ctrl, fbl_dp and the assertion macro header.
//
//   channel   direction  handshake              beat type
//   in        input      in_valid_i/in_stall_o  fbl_pkg::in_t
//   out       output     out_valid_o/out_stall_i fbl_pkg::out_t
//
// Append, read and shrink need no walk; remove pulls down the entries behind the index,
// find and first fit walk up to the first match, best fit walks every entry, insert
// walks to its position and shifts the entries behind it up; the single-ported entry
// memory, one read or write per cycle with a registered read, sets the walk rate.
// Reset clears the entry count, the walk state and the handshake state; entries are
// not cleared since only positions below the count are ever read.
// A finished result sits in the output register while the next beat is
// taken; a result waits in the controller only if that register is still full.
`default_nettype none

module free_block_list_fit_search #(
  parameter int TABLE_DEPTH = fbl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire fbl_pkg::in_t  in_beat_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output fbl_pkg::out_t      out_beat_o
);
  import fbl_pkg::*;

  `include "free_block_list_fit_search_macros.svh"

  // Command and status groups between the sequencer and the datapath.
  fbl_cmd_t  cmd;
  fbl_stat_t stat;

  fbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbl_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_beat_i (in_beat_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_beat_o(out_beat_o)
  );

  // All entry fields of the output beat are zero.
  logic err_fields_zero;
  assign err_fields_zero = (out_beat_o.found_index == '0) &&
                           (out_beat_o.found_address == '0) &&
                           (out_beat_o.found_size == '0);

  // An accepted beat keeps the block busy in the following cycle.
  `FBL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // Error results never carry entry data.
  `FBL_ASSERT_IMPL(a_err_fields_zero, out_valid_o && (out_beat_o.status != ST_OK), err_fields_zero)
  // The table never grows past its depth.
  `FBL_ASSERT_IMPL(a_no_grow_when_full, stat.full, !cmd.cnt_inc)

endmodule

`default_nettype wire

// File: hdl/fbl_dp.sv
// Datapath of the free block list: entry memory, count, walk pointer,
// best-fit tracking and the result registers. Depends on fbl_pkg.
`default_nettype none

module fbl_dp #(
  parameter int TABLE_DEPTH = fbl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fbl_pkg::in_t     in_beat_i,
  input  wire fbl_pkg::fbl_cmd_t cmd_i,
  output fbl_pkg::fbl_stat_t    stat_o,
  output fbl_pkg::out_t         out_beat_o
);
  import fbl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);

  entry_t        mem_q [TABLE_DEPTH];
  entry_t        rd_q;
  in_t           item_q;
  logic [PW-1:0] cnt_q, ptr_q, pos_q;
  logic          hit_q;
  entry_t        best_q;
  out_t          res_q, out_q;
  out_t          out_d;

  logic [PW-1:0] ptr_prev, ptr_next;
  logic [IW-1:0] rd_addr;
  entry_t        wr_data;
  logic [31:0]   shrunk;

  assign ptr_prev = ptr_q - PW'(1);
  assign ptr_next = ptr_q + PW'(1);
  assign shrunk   = rd_q.size - item_q.block_size;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV: rd_addr = ptr_prev[IW-1:0];
      RD_NEXT: rd_addr = ptr_next[IW-1:0];
      default: rd_addr = ptr_q[IW-1:0];
    endcase
    case (cmd_i.wr_sel)
      WR_ITEM:   wr_data = '{addr: item_q.block_address, size: item_q.block_size};
      WR_SHRUNK: wr_data = '{addr: rd_q.addr, size: shrunk};
      default:   wr_data = rd_q;
    endcase
  end

  // The output beat takes the count as it stands once the command is done.
  always_comb begin
    out_d             = res_q;
    out_d.entry_count = 7'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[IW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      pos_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + PW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - PW'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_next;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_prev;
      end else if (cmd_i.ptr_ld_cnt) begin
        ptr_q <= cnt_q;
      end else if (cmd_i.ptr_ld_idx) begin
        ptr_q <= PW'(item_q.entry_index);
      end
      if (cmd_i.best_clr) begin
        hit_q <= 1'b0;
      end else if (cmd_i.best_ld) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.pos_ld || cmd_i.best_ld) begin
        pos_q <= ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_beat_i;
    end
    if (cmd_i.best_ld) begin
      best_q <= rd_q;
    end
    if (cmd_i.res_ld) begin
      res_q.status      <= cmd_i.res_status;
      res_q.entry_count <= '0;
      case (cmd_i.res_sel)
        RES_RD: begin
          res_q.found_index   <= 6'(ptr_q);
          res_q.found_address <= rd_q.addr;
          res_q.found_size    <= rd_q.size;
        end
        RES_ITEM: begin
          res_q.found_index   <= 6'(ptr_q);
          res_q.found_address <= item_q.block_address;
          res_q.found_size    <= item_q.block_size;
        end
        RES_SHRUNK: begin
          res_q.found_index   <= 6'(ptr_q);
          res_q.found_address <= rd_q.addr;
          res_q.found_size    <= shrunk;
        end
        RES_BEST: begin
          res_q.found_index   <= 6'(pos_q);
          res_q.found_address <= best_q.addr;
          res_q.found_size    <= best_q.size;
        end
        default: begin
          res_q.found_index   <= '0;
          res_q.found_address <= '0;
          res_q.found_size    <= '0;
        end
      endcase
    end
    if (cmd_i.out_ld) begin
      out_q <= out_d;
    end
  end

  assign out_beat_o = out_q;

  assign stat_o.cmd         = item_q.cmd;
  assign stat_o.full        = (cnt_q == PW'(TABLE_DEPTH));
  assign stat_o.idx_bad     = ((PW + 6)'(item_q.entry_index) >= (PW + 6)'(cnt_q));
  assign stat_o.ptr_end     = (ptr_q >= cnt_q);
  assign stat_o.ptr_gt_pos  = (ptr_q > pos_q);
  assign stat_o.pull_end    = ((PW + 1)'(ptr_q) + (PW + 1)'(1) >= (PW + 1)'(cnt_q));
  assign stat_o.addr_lt     = (rd_q.addr < item_q.block_address);
  assign stat_o.addr_eq     = (rd_q.addr == item_q.block_address);
  assign stat_o.size_fit    = (rd_q.size >= item_q.request_size);
  assign stat_o.size_better = !hit_q || (rd_q.size < best_q.size);
  assign stat_o.shrink_bad  = (item_q.block_size > rd_q.size);
  assign stat_o.hit         = hit_q;

endmodule

`default_nettype wire

// File: hdl/fbl_ctrl.sv
// Controller of the free block list: sequences memory walks per command
// and owns the handshakes. Depends on fbl_pkg.
`default_nettype none

module fbl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire fbl_pkg::fbl_stat_t stat_i,
  output fbl_pkg::fbl_cmd_t      cmd_o
);
  import fbl_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_EV  = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_PUT      = 4'd6;
  localparam logic [3:0] S_IDX_RD   = 4'd7;
  localparam logic [3:0] S_IDX_EV   = 4'd8;
  localparam logic [3:0] S_PULL_RD  = 4'd9;
  localparam logic [3:0] S_PULL_WR  = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  fbl_cmd_t   c;

  always_comb begin
    state_d      = state_q;
    c.load_item  = 1'b0;
    c.ptr_clr    = 1'b0;
    c.ptr_inc    = 1'b0;
    c.ptr_dec    = 1'b0;
    c.ptr_ld_cnt = 1'b0;
    c.ptr_ld_idx = 1'b0;
    c.pos_ld     = 1'b0;
    c.best_clr   = 1'b0;
    c.best_ld    = 1'b0;
    c.rd_en      = 1'b0;
    c.rd_sel     = RD_PTR;
    c.wr_en      = 1'b0;
    c.wr_sel     = WR_RD;
    c.cnt_inc    = 1'b0;
    c.cnt_dec    = 1'b0;
    c.res_ld     = 1'b0;
    c.res_sel    = RES_ERR;
    c.res_status = ST_OK;
    c.out_ld     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c.load_item = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_APPEND, CMD_INSERT: begin
            if (stat_i.full) begin
              c.res_ld     = 1'b1;
              c.res_status = ST_FULL;
              state_d      = S_FIN;
            end else if (stat_i.cmd == CMD_APPEND) begin
              c.ptr_ld_cnt = 1'b1;
              state_d      = S_PUT;
            end else begin
              c.ptr_clr = 1'b1;
              state_d   = S_SCAN_RD;
            end
          end
          CMD_FIRST_FIT, CMD_BEST_FIT, CMD_FIND_ADDR: begin
            c.ptr_clr  = 1'b1;
            c.best_clr = 1'b1;
            state_d    = S_SCAN_RD;
          end
          default: begin
            if (stat_i.idx_bad) begin
              c.res_ld     = 1'b1;
              c.res_status = ST_BADINDEX;
              state_d      = S_FIN;
            end else begin
              c.ptr_ld_idx = 1'b1;
              state_d      = S_IDX_RD;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        if (!stat_i.ptr_end) begin
          c.rd_en = 1'b1;
          state_d = S_SCAN_EV;
        end else if (stat_i.cmd == CMD_INSERT) begin
          c.pos_ld     = 1'b1;
          c.ptr_ld_cnt = 1'b1;
          state_d      = S_SHIFT_RD;
        end else if (stat_i.cmd == CMD_BEST_FIT && stat_i.hit) begin
          c.res_ld  = 1'b1;
          c.res_sel = RES_BEST;
          state_d   = S_FIN;
        end else begin
          c.res_ld     = 1'b1;
          c.res_status = ST_NOTFOUND;
          state_d      = S_FIN;
        end
      end
      S_SCAN_EV: begin
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.addr_lt) begin
              c.ptr_inc = 1'b1;
              state_d   = S_SCAN_RD;
            end else begin
              c.pos_ld     = 1'b1;
              c.ptr_ld_cnt = 1'b1;
              state_d      = S_SHIFT_RD;
            end
          end
          CMD_FIRST_FIT, CMD_FIND_ADDR: begin
            if ((stat_i.cmd == CMD_FIRST_FIT) ? stat_i.size_fit : stat_i.addr_eq) begin
              c.res_ld  = 1'b1;
              c.res_sel = RES_RD;
              state_d   = S_FIN;
            end else begin
              c.ptr_inc = 1'b1;
              state_d   = S_SCAN_RD;
            end
          end
          default: begin
            c.best_ld = stat_i.size_fit && stat_i.size_better;
            c.ptr_inc = 1'b1;
            state_d   = S_SCAN_RD;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat_i.ptr_gt_pos) begin
          c.rd_en  = 1'b1;
          c.rd_sel = RD_PREV;
          state_d  = S_SHIFT_WR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SHIFT_WR: begin
        c.wr_en   = 1'b1;
        c.ptr_dec = 1'b1;
        state_d   = S_SHIFT_RD;
      end
      S_PUT: begin
        c.wr_en   = 1'b1;
        c.wr_sel  = WR_ITEM;
        c.cnt_inc = 1'b1;
        c.res_ld  = 1'b1;
        c.res_sel = RES_ITEM;
        state_d   = S_FIN;
      end
      S_IDX_RD: begin
        c.rd_en = 1'b1;
        state_d = S_IDX_EV;
      end
      S_IDX_EV: begin
        c.res_ld = 1'b1;
        case (stat_i.cmd)
          CMD_REMOVE: begin
            c.res_sel = RES_RD;
            state_d   = S_PULL_RD;
          end
          CMD_SHRINK: begin
            if (stat_i.shrink_bad) begin
              c.res_status = ST_BADINDEX;
            end else begin
              c.wr_en   = 1'b1;
              c.wr_sel  = WR_SHRUNK;
              c.res_sel = RES_SHRUNK;
            end
            state_d = S_FIN;
          end
          default: begin
            c.res_sel = RES_RD;
            state_d   = S_FIN;
          end
        endcase
      end
      S_PULL_RD: begin
        if (stat_i.pull_end) begin
          c.cnt_dec = 1'b1;
          state_d   = S_FIN;
        end else begin
          c.rd_en  = 1'b1;
          c.rd_sel = RD_NEXT;
          state_d  = S_PULL_WR;
        end
      end
      S_PULL_WR: begin
        c.wr_en   = 1'b1;
        c.ptr_inc = 1'b1;
        state_d   = S_PULL_RD;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          c.out_ld = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (c.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = c;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: test/free_block_list_fit_search_tb.sv
// Self-checking testbench for free_block_list_fit_search.
// Depends on fbl_pkg and the block; drives command beats, predicts each result
// from a private table model and compares every result beat field by field.
`default_nettype none

module free_block_list_fit_search_tb;
  import fbl_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_beat_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_beat_o;

  free_block_list_fit_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  // Private copy of the block table used to predict results.
  logic [31:0] tbl_addr [DEPTH];
  logic [31:0] tbl_size [DEPTH];
  int          tbl_count;

  in_t  pending_cmds[$];
  out_t expected_results[$];
  int   failures;
  bit   stim_done;

  // Result beat for a table position, or an error beat with zeroed entry fields.
  function automatic out_t make_result(logic [1:0] st, int pos);
    out_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.found_index   = pos[5:0];
      r.found_address = tbl_addr[pos];
      r.found_size    = tbl_size[pos];
    end
    r.entry_count = tbl_count[6:0];
    return r;
  endfunction

  // Applies one command to the table copy and returns the result it causes.
  function automatic out_t apply_table_cmd(in_t c);
    out_t r;
    int pos;
    bit hit;
    logic [31:0] ra, rs;
    case (c.cmd)
      CMD_APPEND, CMD_INSERT: begin
        if (tbl_count >= DEPTH) return make_result(ST_FULL, 0);
        pos = tbl_count;
        if (c.cmd == CMD_INSERT) begin
          pos = 0;
          while (pos < tbl_count && tbl_addr[pos] < c.block_address) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_addr[i] = tbl_addr[i-1];
            tbl_size[i] = tbl_size[i-1];
          end
        end
        tbl_addr[pos] = c.block_address;
        tbl_size[pos] = c.block_size;
        tbl_count++;
        return make_result(ST_OK, pos);
      end
      CMD_FIRST_FIT: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_size[i] >= c.request_size) return make_result(ST_OK, i);
        return make_result(ST_NOTFOUND, 0);
      end
      CMD_BEST_FIT: begin
        hit = 0;
        pos = 0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_size[i] >= c.request_size && (!hit || tbl_size[i] < tbl_size[pos])) begin
            hit = 1;
            pos = i;
          end
        return make_result(hit ? ST_OK : ST_NOTFOUND, pos);
      end
      CMD_FIND_ADDR: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_addr[i] == c.block_address) return make_result(ST_OK, i);
        return make_result(ST_NOTFOUND, 0);
      end
      CMD_REMOVE: begin
        if (c.entry_index >= tbl_count) return make_result(ST_BADINDEX, 0);
        ra = tbl_addr[c.entry_index];
        rs = tbl_size[c.entry_index];
        for (int i = c.entry_index; i + 1 < tbl_count; i++) begin
          tbl_addr[i] = tbl_addr[i+1];
          tbl_size[i] = tbl_size[i+1];
        end
        tbl_count--;
        r = '0;
        r.status        = ST_OK;
        r.found_index   = c.entry_index;
        r.found_address = ra;
        r.found_size    = rs;
        r.entry_count   = tbl_count[6:0];
        return r;
      end
      CMD_SHRINK: begin
        if (c.entry_index >= tbl_count || c.block_size > tbl_size[c.entry_index])
          return make_result(ST_BADINDEX, 0);
        tbl_size[c.entry_index] -= c.block_size;
        return make_result(ST_OK, c.entry_index);
      end
      default: begin
        if (c.entry_index >= tbl_count) return make_result(ST_BADINDEX, 0);
        return make_result(ST_OK, c.entry_index);
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sizes and addresses drawn from a small pool so that ties and exact
  // matches happen, with full-range values mixed in.
  function automatic logic [31:0] pick_word(bit narrow);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'hFFFF_FFFF;
    if (roll == 1) return 32'h0;
    if (narrow || roll < 7) return $urandom_range(0, 40);
    return $urandom();
  endfunction

  function automatic in_t make_cmd(logic [2:0] op, logic [31:0] a, logic [31:0] s,
                                   logic [31:0] q, logic [5:0] ix);
    in_t c;
    c.cmd           = op;
    c.block_address = a;
    c.block_size    = s;
    c.request_size  = q;
    c.entry_index   = ix;
    return c;
  endfunction

  // Adds a command beat at the tail of the pending queue.
  task automatic queue_cmd(in_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: one beat at a time from the pending queue; the prediction is made
  // at the accepting edge so the table copy follows the block's order.
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_gap <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_results = {expected_results, apply_table_cmd(in_beat_i)};
      void'(pending_cmds.pop_front());
      in_gap <= pick_gap();
    end else if (!in_valid_i && in_gap > 0) begin
      in_gap <= in_gap - 1;
    end
  end

  // Inputs move on the falling edge; valid holds while a beat waits.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_gap == 0 && pending_cmds.size() > 0) begin
      in_valid_i <= 1'b1;
      in_beat_i  <= pending_cmds[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: compare every accepted result beat with the oldest prediction.
  int out_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      out_hold <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected: %p", $time, out_beat_o);
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_beat_o.status !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                     out_beat_o.status);
            failures++;
          end
          if (out_beat_o.found_index !== exp_r.found_index) begin
            $display("%0t: found_index expected %0d got %0d", $time,
                     exp_r.found_index, out_beat_o.found_index);
            failures++;
          end
          if (out_beat_o.found_address !== exp_r.found_address) begin
            $display("%0t: found_address expected %h got %h", $time,
                     exp_r.found_address, out_beat_o.found_address);
            failures++;
          end
          if (out_beat_o.found_size !== exp_r.found_size) begin
            $display("%0t: found_size expected %h got %h", $time,
                     exp_r.found_size, out_beat_o.found_size);
            failures++;
          end
          if (out_beat_o.entry_count !== exp_r.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time,
                     exp_r.entry_count, out_beat_o.entry_count);
            failures++;
          end
        end
      end
      if (out_hold > 0) out_hold <= out_hold - 1;
      else if ($urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (rst_ni && out_hold > 0);
  end

  // Stimulus: directed corners first, then random phases that fill, churn
  // and drain the table so every count from empty to full is visited.
  initial begin
    int fill_bias;
    logic [2:0] op;
    failures   = 0;
    stim_done  = 0;
    rst_ni     = 1'b0;
    // Empty table: every search misses and every position is bad.
    queue_cmd(make_cmd(CMD_FIRST_FIT, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_BEST_FIT, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_FIND_ADDR, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_REMOVE, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_SHRINK, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 6'h3F));
    // Extreme values, insertion in front and in the middle, and an equal address.
    queue_cmd(make_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_INSERT, 32'h0, 32'd8, 0, 0));
    queue_cmd(make_cmd(CMD_INSERT, 32'h100, 32'd8, 0, 0));
    queue_cmd(make_cmd(CMD_INSERT, 32'h100, 32'd4, 0, 0));
    // Best fit tie between equal sizes, first fit taking the earliest.
    queue_cmd(make_cmd(CMD_BEST_FIT, 0, 0, 32'd5, 0));
    queue_cmd(make_cmd(CMD_FIRST_FIT, 0, 0, 32'd5, 0));
    queue_cmd(make_cmd(CMD_BEST_FIT, 0, 0, 32'hFFFF_FFFF, 0));
    queue_cmd(make_cmd(CMD_FIRST_FIT, 0, 0, 32'hFFFF_FFFF, 0));
    queue_cmd(make_cmd(CMD_FIND_ADDR, 32'h100, 0, 0, 0));
    queue_cmd(make_cmd(CMD_FIND_ADDR, 32'h5, 0, 0, 0));
    // Shrink to exactly zero, then an underflowing shrink.
    queue_cmd(make_cmd(CMD_SHRINK, 0, 32'd8, 0, 6'd0));
    queue_cmd(make_cmd(CMD_SHRINK, 0, 32'd1, 0, 6'd0));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 6'd3));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 6'd4));
    queue_cmd(make_cmd(CMD_REMOVE, 0, 0, 0, 6'd1));
    queue_cmd(make_cmd(CMD_REMOVE, 0, 0, 0, 6'd2));
    queue_cmd(make_cmd(CMD_REMOVE, 0, 0, 0, 6'd0));
    for (int ph = 0; ph < 13; ph++) begin
      // Alternate filling and draining phases; fill phases reach a full table.
      fill_bias = (ph % 2 == 0) ? 70 : 15;
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(0, 99) < fill_bias / 2) op = 3'($urandom_range(0, 1));
        else if ($urandom_range(0, 99) < fill_bias / 3) op = 3'($urandom_range(0, 1));
        else if ($urandom_range(0, 99) < 30 - fill_bias / 4) op = CMD_REMOVE;
        else op = 3'($urandom_range(2, 7));
        queue_cmd(make_cmd(op, pick_word(0), pick_word(0), pick_word(1),
                           $urandom_range(0, 3) == 0 ?
                           6'($urandom()) : 6'($urandom_range(0, 20))));
      end
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Slowest run: about 1070 beats plus gaps and stalls.
  initial begin
    #(20 * 1000000);
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// File: free_block_list_fit_search.f
+incdir+hdl
hdl/fbl_pkg.sv
hdl/fbl_dp.sv
hdl/fbl_ctrl.sv
hdl/free_block_list_fit_search.sv
test/free_block_list_fit_search_tb.sv
